### rtl/lt_ir_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse decoder package
// Shared widths, reset values, phase and event codes, and the word that the
// classifier hands to the packet sequencer.
// ----------------------------------------------------------------------------
package lt_ir_pkg;

   localparam int TICK_WIDTH_DEFAULT = 24;
   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int COUNT_WIDTH        = 8;
   localparam int EVENT_WIDTH        = 4;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int QUEUE_DEPTH        = 2;

   localparam int RESET_MARGIN          = 499;
   localparam int RESET_SHORT_PULSE_LEN = 2999;
   localparam int RESET_LONG_PULSE_LEN  = 5999;
   localparam int RESET_BIT_PAUSE_LEN   = 1999;
   localparam int RESET_ZERO_LEN        = 999;
   localparam int RESET_ONE_LEN         = 1999;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PSP      = 3'd1,
      PH_SYNC     = 3'd2,
      PH_BITPAUSE = 3'd3,
      PH_BIT      = 3'd4
   } lt_ir_phase_type;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_PRESYNC       = 4'd0,
      EV_PRESYNC_PAUSE = 4'd1,
      EV_SYNC          = 4'd2,
      EV_LONG_SYNC     = 4'd3,
      EV_BIT_PAUSE     = 4'd4,
      EV_BIT           = 4'd5,
      EV_SIG           = 4'd6,
      EV_LONG_SIG      = 4'd7,
      EV_ERROR         = 4'd8
   } lt_ir_event_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_LEVEL    = 3'd0,
      CSR_MARGIN          = 3'd1,
      CSR_SHORT_PULSE_LEN = 3'd2,
      CSR_LONG_PULSE_LEN  = 3'd3,
      CSR_BIT_PAUSE_LEN   = 3'd4,
      CSR_ZERO_LEN        = 3'd5,
      CSR_ONE_LEN         = 3'd6
   } lt_ir_csr_type;

   // window hits of one interval, independent of the packet phase
   typedef struct packed {
      logic short_hit;
      logic long_hit;
      logic pause_hit;
      logic zero_hit;
      logic one_hit;
      logic level_hit;
   } lt_ir_class_type;

endpackage

### rtl/lt_ir_if.sv
// ----------------------------------------------------------------------------
// IR pulse decoder channels
// Valid/ready channels for interval words, result words and register writes.
// ----------------------------------------------------------------------------
interface lt_ir_req_if #(
   parameter int TICK_WIDTH = lt_ir_pkg::TICK_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [TICK_WIDTH-1:0] interval;
   logic                  level;

   modport source (output valid, output interval, output level, input ready);
   modport sink   (input valid, input interval, input level, output ready);
endinterface

interface lt_ir_rsp_if #(
   parameter int DATA_WIDTH = lt_ir_pkg::DATA_WIDTH_DEFAULT
);
   import lt_ir_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [EVENT_WIDTH-1:0] event_res;
   logic                   bit_value;
   logic [COUNT_WIDTH-1:0] bit_count;
   logic [DATA_WIDTH-1:0]  signature_data;

   modport source (output valid, output event_res, output bit_value, output bit_count,
                   output signature_data, input ready);
   modport sink   (input valid, input event_res, input bit_value, input bit_count,
                   input signature_data, output ready);
endinterface

interface lt_ir_csr_if #(
   parameter int TICK_WIDTH = lt_ir_pkg::TICK_WIDTH_DEFAULT
);
   import lt_ir_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [TICK_WIDTH-1:0]      wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/lt_ir_front.sv
// ----------------------------------------------------------------------------
// IR pulse decoder front end
// Holds the timing registers, accepts interval words and tests each one
// against every acceptance window.
// ----------------------------------------------------------------------------
module lt_ir_front #(
   parameter int TICK_WIDTH = lt_ir_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   lt_ir_req_if.sink                  req_bus,
   lt_ir_csr_if.sink                  csr_bus,
   input  logic                       q_full,
   output logic                       q_push,
   output lt_ir_pkg::lt_ir_class_type q_word
);
   import lt_ir_pkg::*;

   logic                  active_level_ff, active_level_in;
   logic [TICK_WIDTH-1:0] margin_ff, margin_in;
   logic [TICK_WIDTH-1:0] short_len_ff, short_len_in;
   logic [TICK_WIDTH-1:0] long_len_ff, long_len_in;
   logic [TICK_WIDTH-1:0] pause_len_ff, pause_len_in;
   logic [TICK_WIDTH-1:0] zero_len_ff, zero_len_in;
   logic [TICK_WIDTH-1:0] one_len_ff, one_len_in;
   logic [TICK_WIDTH:0]   t_plus_m;

   // t in [len-m, len+m) with the lower edge clamped at zero:
   // t+m >= len covers the clamp, since t+m >= m > len there
   function automatic logic in_window(input logic [TICK_WIDTH:0] tpm,
                                      input logic [TICK_WIDTH-1:0] t,
                                      input logic [TICK_WIDTH-1:0] len,
                                      input logic [TICK_WIDTH-1:0] m);
      logic [TICK_WIDTH:0] hi;
      hi = {1'b0, len} + {1'b0, m};
      return (tpm >= {1'b0, len}) && ({1'b0, t} < hi);
   endfunction

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;

   assign t_plus_m = {1'b0, req_bus.interval} + {1'b0, margin_ff};

   always_comb begin
      q_word.short_hit = in_window(t_plus_m, req_bus.interval, short_len_ff, margin_ff);
      q_word.long_hit  = in_window(t_plus_m, req_bus.interval, long_len_ff, margin_ff);
      q_word.pause_hit = in_window(t_plus_m, req_bus.interval, pause_len_ff, margin_ff);
      q_word.zero_hit  = in_window(t_plus_m, req_bus.interval, zero_len_ff, margin_ff);
      q_word.one_hit   = in_window(t_plus_m, req_bus.interval, one_len_ff, margin_ff);
      q_word.level_hit = (req_bus.level == active_level_ff);
   end

   always_comb begin
      active_level_in = active_level_ff;
      margin_in       = margin_ff;
      short_len_in    = short_len_ff;
      long_len_in     = long_len_ff;
      pause_len_in    = pause_len_ff;
      zero_len_in     = zero_len_ff;
      one_len_in      = one_len_ff;
      if (csr_bus.valid) begin
         case (lt_ir_csr_type'(csr_bus.reg_index))
            CSR_ACTIVE_LEVEL:    active_level_in = csr_bus.wr_data[0];
            CSR_MARGIN:          margin_in       = csr_bus.wr_data;
            CSR_SHORT_PULSE_LEN: short_len_in    = csr_bus.wr_data;
            CSR_LONG_PULSE_LEN:  long_len_in     = csr_bus.wr_data;
            CSR_BIT_PAUSE_LEN:   pause_len_in    = csr_bus.wr_data;
            CSR_ZERO_LEN:        zero_len_in     = csr_bus.wr_data;
            CSR_ONE_LEN:         one_len_in      = csr_bus.wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b0;
         margin_ff       <= TICK_WIDTH'(RESET_MARGIN);
         short_len_ff    <= TICK_WIDTH'(RESET_SHORT_PULSE_LEN);
         long_len_ff     <= TICK_WIDTH'(RESET_LONG_PULSE_LEN);
         pause_len_ff    <= TICK_WIDTH'(RESET_BIT_PAUSE_LEN);
         zero_len_ff     <= TICK_WIDTH'(RESET_ZERO_LEN);
         one_len_ff      <= TICK_WIDTH'(RESET_ONE_LEN);
      end else begin
         active_level_ff <= active_level_in;
         margin_ff       <= margin_in;
         short_len_ff    <= short_len_in;
         long_len_ff     <= long_len_in;
         pause_len_ff    <= pause_len_in;
         zero_len_ff     <= zero_len_in;
         one_len_ff      <= one_len_in;
      end
   end

endmodule

### rtl/lt_ir_queue.sv
// ----------------------------------------------------------------------------
// IR pulse decoder queue
// Short first-in first-out buffer of classified words between the front end
// and the packet sequencer.
// ----------------------------------------------------------------------------
module lt_ir_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lt_ir_pkg::lt_ir_class_type push_word,
   output logic                       full,
   input  logic                       pop,
   output logic                       pop_valid,
   output lt_ir_pkg::lt_ir_class_type pop_word
);
   import lt_ir_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   lt_ir_class_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/lt_ir_back.sv
// ----------------------------------------------------------------------------
// IR pulse decoder packet sequencer
// Walks the packet phases on classified words, shifts in data bits and
// loads result words into the output register.
// ----------------------------------------------------------------------------
module lt_ir_back #(
   parameter int DATA_WIDTH = lt_ir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  lt_ir_pkg::lt_ir_class_type q_word,
   output logic                       q_pop,
   lt_ir_rsp_if.source                rsp_bus
);
   import lt_ir_pkg::*;

   lt_ir_phase_type        phase_ff, phase_in;
   logic [DATA_WIDTH-1:0]  shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] seen_ff, seen_in;
   logic                   long_seen_ff, long_seen_in;

   logic                   valid_ff, valid_in;
   lt_ir_event_type        event_ff, event_in;
   logic                   bit_ff, bit_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DATA_WIDTH-1:0]  data_ff, data_in;
   logic                   has_res;

   // advance whenever the output register is free or being emptied
   assign q_pop = q_valid && (!valid_ff || rsp_bus.ready);

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      seen_in      = seen_ff;
      long_seen_in = long_seen_ff;
      has_res      = 1'b0;
      event_in     = EV_ERROR;
      bit_in       = 1'b0;
      count_in     = '0;
      data_in      = '0;
      if (q_pop) begin
         has_res = 1'b1;
         case (phase_ff)
            PH_PSP: begin
               if (q_word.long_hit) begin
                  phase_in = PH_SYNC;
                  event_in = EV_PRESYNC_PAUSE;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SYNC: begin
               if (q_word.short_hit) begin
                  phase_in = PH_BITPAUSE;
                  event_in = EV_SYNC;
               end else if (q_word.long_hit) begin
                  phase_in     = PH_BITPAUSE;
                  long_seen_in = 1'b1;
                  event_in     = EV_LONG_SYNC;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_BITPAUSE: begin
               if (q_word.pause_hit) begin
                  phase_in = PH_BIT;
                  event_in = EV_BIT_PAUSE;
               end else begin
                  phase_in = PH_IDLE;
                  // packet over: report the signature, or an error word if no bit came
                  if (seen_ff != '0) begin
                     event_in = long_seen_ff ? EV_LONG_SIG : EV_SIG;
                     count_in = seen_ff;
                     data_in  = shift_ff;
                  end
               end
            end
            PH_BIT: begin
               if (q_word.zero_hit || q_word.one_hit) begin
                  // zero window wins where the two overlap
                  bit_in   = !q_word.zero_hit;
                  shift_in = {shift_ff[DATA_WIDTH-2:0], !q_word.zero_hit};
                  if (seen_ff != {COUNT_WIDTH{1'b1}}) begin
                     seen_in = seen_ff + 1'b1;
                  end
                  phase_in = PH_BITPAUSE;
                  event_in = EV_BIT;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (q_word.short_hit && q_word.level_hit) begin
                  shift_in     = '0;
                  seen_in      = '0;
                  long_seen_in = 1'b0;
                  phase_in     = PH_PSP;
                  event_in     = EV_PRESYNC;
               end else begin
                  // drop: noise while idle gives no word
                  has_res = 1'b0;
               end
            end
         endcase
      end
      valid_in = valid_ff && !rsp_bus.ready;
      if (has_res) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= '0;
         seen_ff      <= '0;
         long_seen_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         seen_ff      <= seen_in;
         long_seen_ff <= long_seen_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (has_res) begin
         event_ff <= event_in;
         bit_ff   <= bit_in;
         count_ff <= count_in;
         data_ff  <= data_in;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.event_res      = event_ff;
   assign rsp_bus.bit_value      = bit_ff;
   assign rsp_bus.bit_count      = count_ff;
   assign rsp_bus.signature_data = data_ff;

endmodule

### rtl/laser_tag_ir_pulse_decoder_unit.sv
// ----------------------------------------------------------------------------
// IR pulse-width packet decoder
// Decodes pre-sync, sync and pulse-width data bits from pin edge intervals.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one word per pin edge (or upstream bit-pause timeout):
//   the interval in ticks and the pin level held during it.
//   rsp_bus returns at most one word per request: an event code, the bit
//   value for bit events, and count plus shifted data for signatures.
//   csr_bus writes the timing registers; write them only while idle.
//   Order: the accepting edge writes the classified word into the queue;
//   the sequencer pops it once the output register is free or being
//   emptied and loads the result there, which drives rsp_bus valid.
//   Throughput: one word per cycle while rsp_bus is not stalled, set by
//   the phase update in the sequencer; the window compares run in parallel.
//   Idle words that do not start a packet are consumed with no result.
//   When rsp_bus stalls, the result holds, the two-entry queue fills and
//   req_bus ready drops only once it is full.
//   Reset restores the register defaults, returns to idle and clears the
//   bit counter and shift register.
// ----------------------------------------------------------------------------
module laser_tag_ir_pulse_decoder_unit #(
   parameter int TICK_WIDTH = lt_ir_pkg::TICK_WIDTH_DEFAULT,
   parameter int DATA_WIDTH = lt_ir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lt_ir_req_if.sink   req_bus,
   lt_ir_rsp_if.source rsp_bus,
   lt_ir_csr_if.sink   csr_bus
);
   import lt_ir_pkg::*;

   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_valid;
   lt_ir_class_type push_word;
   lt_ir_class_type pop_word;

   lt_ir_front #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_word  (push_word)
   );

   lt_ir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (pop_word)
   );

   lt_ir_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_word  (pop_word),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into a full queue");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      (q_valid && (!rsp_bus.valid || rsp_bus.ready)) |-> q_pop)
      else $error("sequencer stalled with a free output register");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_bus.ready)
      else $error("request taken while queue full");

endmodule
